// ===== design/hsv_pkg.sv =====
// ---------------------------------------------------------------------------
// hsv_pkg
// Shared types and constants for the hsv to rgb pixel unit.
// ---------------------------------------------------------------------------
package hsv_pkg;

  typedef struct packed {
    logic [14:0] hue;
    logic [7:0]  saturation;
    logic [7:0]  brightness;
  } pixel_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } color_t;

  // classified pixel handed from the front end to the back end
  typedef struct packed {
    logic [2:0]  sector;
    logic [11:0] k;
    logic [7:0]  saturation;
    logic [7:0]  brightness;
  } work_t;

  localparam logic [2:0] SECTOR_RED_GREEN   = 3'd0;
  localparam logic [2:0] SECTOR_GREEN_RED   = 3'd1;
  localparam logic [2:0] SECTOR_GREEN_BLUE  = 3'd2;
  localparam logic [2:0] SECTOR_BLUE_GREEN  = 3'd3;
  localparam logic [2:0] SECTOR_BLUE_RED    = 3'd4;
  localparam logic [2:0] SECTOR_RED_BLUE    = 3'd5;

  // 60 degrees in 1/64 degree units
  localparam logic [12:0] HUE_SECTOR = 13'd3840;
  localparam logic [14:0] HUE_BOUND1 = 15'd3840;
  localparam logic [14:0] HUE_BOUND2 = 15'd7680;
  localparam logic [14:0] HUE_BOUND3 = 15'd11520;
  localparam logic [14:0] HUE_BOUND4 = 15'd15360;
  localparam logic [14:0] HUE_BOUND5 = 15'd19200;

  localparam logic [7:0]  FULL_SCALE = 8'd255;
  localparam logic [15:0] LOW_BIAS   = 16'd127;
  // ceil(2^24 / 255), exact for dividends below 65536
  localparam logic [16:0] LOW_RECIP  = 17'd65794;
  // half of 255 * 3840
  localparam logic [27:0] INTER_BIAS = 28'd489600;
  // ceil(2^32 / 3825), applied after a shift by 8 (255 * 3840 = 256 * 3825)
  localparam logic [20:0] INTER_RECIP = 21'd1122868;

  localparam int unsigned QUEUE_DEPTH = 2;

  // hue[14:9] mod 15, since 7680 = 512 * 15
  function automatic logic [3:0] period_mod(input logic [5:0] q);
    logic [5:0] m;
    if (q < 6'd15) begin
      m = q;
    end else if (q < 6'd30) begin
      m = q - 6'd15;
    end else if (q < 6'd45) begin
      m = q - 6'd30;
    end else if (q < 6'd60) begin
      m = q - 6'd45;
    end else begin
      m = q - 6'd60;
    end
    return m[3:0];
  endfunction

endpackage

// ===== design/hsv_front.sv =====
// ---------------------------------------------------------------------------
// hsv_front
// Accepts pixels, finds the hue sector and the intermediate weight k.
// ---------------------------------------------------------------------------
module hsv_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  hsv_pkg::pixel_t pixel,
  output logic            busy,
  output logic            work_valid,
  output hsv_pkg::work_t  work,
  input  logic            work_ready
);

  logic           advance;
  logic [12:0]    r;
  logic [12:0]    hue_gap;
  logic [12:0]    k_full;
  logic [2:0]     sector;
  hsv_pkg::work_t work_next;

  assign advance = !work_valid || work_ready;
  assign busy    = !advance;

  // position within the 120 degree period
  assign r = {hsv_pkg::period_mod(pixel.hue[14:9]), pixel.hue[8:0]};
  assign hue_gap = (r >= hsv_pkg::HUE_SECTOR) ? (r - hsv_pkg::HUE_SECTOR)
                                              : (hsv_pkg::HUE_SECTOR - r);
  assign k_full = hsv_pkg::HUE_SECTOR - hue_gap;

  always_comb begin
    priority if (pixel.hue <= hsv_pkg::HUE_BOUND1) begin
      sector = hsv_pkg::SECTOR_RED_GREEN;
    end else if (pixel.hue <= hsv_pkg::HUE_BOUND2) begin
      sector = hsv_pkg::SECTOR_GREEN_RED;
    end else if (pixel.hue <= hsv_pkg::HUE_BOUND3) begin
      sector = hsv_pkg::SECTOR_GREEN_BLUE;
    end else if (pixel.hue <= hsv_pkg::HUE_BOUND4) begin
      sector = hsv_pkg::SECTOR_BLUE_GREEN;
    end else if (pixel.hue <= hsv_pkg::HUE_BOUND5) begin
      sector = hsv_pkg::SECTOR_BLUE_RED;
    end else begin
      sector = hsv_pkg::SECTOR_RED_BLUE;
    end
  end

  always_comb begin
    work_next.sector     = sector;
    work_next.k          = k_full[11:0];
    work_next.saturation = pixel.saturation;
    work_next.brightness = pixel.brightness;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      work_valid <= 1'b0;
    end else if (advance) begin
      work_valid <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && start) begin
      work <= work_next;
    end
  end

endmodule

// ===== design/hsv_queue.sv =====
// ---------------------------------------------------------------------------
// hsv_queue
// Short fifo between the front end and the back end.
// ---------------------------------------------------------------------------
module hsv_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  input  hsv_pkg::work_t push_data,
  output logic           push_ready,
  output logic           pop_valid,
  output hsv_pkg::work_t pop_data
);

  localparam int unsigned PtrW = $clog2(hsv_pkg::QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(hsv_pkg::QUEUE_DEPTH + 1);

  hsv_pkg::work_t entries [hsv_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            push;
  logic            pop;

  // the back end never stalls, so anything stored leaves next cycle
  assign pop_valid  = (count != '0);
  assign pop        = pop_valid;
  assign push_ready = (count != CntW'(hsv_pkg::QUEUE_DEPTH)) || pop;
  assign push       = push_valid && push_ready;
  assign pop_data   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(hsv_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(hsv_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== design/hsv_back.sv =====
// ---------------------------------------------------------------------------
// hsv_back
// Three stage datapath: products, levels, channel routing.
// ---------------------------------------------------------------------------
module hsv_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            work_valid,
  input  hsv_pkg::work_t  work,
  output logic            done,
  output hsv_pkg::color_t color
);

  // stage 1: 8x8 products
  logic        s1_valid;
  logic [15:0] s1_base;
  logic [15:0] s1_sv;
  logic [11:0] s1_k;
  logic [2:0]  s1_sector;
  logic [7:0]  s1_full;

  // stage 2: numerator of the intermediate level and the low level
  logic        s2_valid;
  logic [27:0] s2_num;
  logic [7:0]  s2_low;
  logic [2:0]  s2_sector;
  logic [7:0]  s2_full;

  logic [15:0] low_dividend;
  logic [32:0] low_prod;
  logic [27:0] svk;
  logic [27:0] num_next;
  logic [27:0] inter_dividend;
  logic [40:0] inter_prod;
  logic [7:0]  inter;
  hsv_pkg::color_t color_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s1_valid <= work_valid;
      s2_valid <= s1_valid;
      done     <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_base   <= 16'(work.brightness) * 16'(hsv_pkg::FULL_SCALE - work.saturation);
    s1_sv     <= 16'(work.saturation) * 16'(work.brightness);
    s1_k      <= work.k;
    s1_sector <= work.sector;
    s1_full   <= work.brightness;
  end

  // base * 3840 done as base * 4096 - base * 256
  assign svk      = 28'(s1_sv) * 28'(s1_k);
  assign num_next = (28'(s1_base) << 12) - (28'(s1_base) << 8) + svk;

  // round half up of base / 255
  assign low_dividend = s1_base + hsv_pkg::LOW_BIAS;
  assign low_prod     = 33'(low_dividend) * 33'(hsv_pkg::LOW_RECIP);

  always_ff @(posedge clk) begin
    s2_num    <= num_next;
    s2_low    <= low_prod[31:24];
    s2_sector <= s1_sector;
    s2_full   <= s1_full;
  end

  // round half up of num / (255 * 3840)
  assign inter_dividend = s2_num + hsv_pkg::INTER_BIAS;
  assign inter_prod     = 41'(inter_dividend[27:8]) * 41'(hsv_pkg::INTER_RECIP);
  assign inter          = inter_prod[39:32];

  always_comb begin
    unique case (s2_sector)
      hsv_pkg::SECTOR_RED_GREEN: begin
        color_next = '{red: s2_full, green: inter, blue: s2_low};
      end
      hsv_pkg::SECTOR_GREEN_RED: begin
        color_next = '{red: inter, green: s2_full, blue: s2_low};
      end
      hsv_pkg::SECTOR_GREEN_BLUE: begin
        color_next = '{red: s2_low, green: s2_full, blue: inter};
      end
      hsv_pkg::SECTOR_BLUE_GREEN: begin
        color_next = '{red: s2_low, green: inter, blue: s2_full};
      end
      hsv_pkg::SECTOR_BLUE_RED: begin
        color_next = '{red: inter, green: s2_low, blue: s2_full};
      end
      default: begin
        color_next = '{red: s2_full, green: s2_low, blue: inter};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    color <= color_next;
  end

endmodule

// ===== design/hsv_to_rgb_pixel_unit.sv =====
// ---------------------------------------------------------------------------
// hsv_to_rgb_pixel_unit
// Converts one hsv pixel per clock into 8-bit red, green and blue.
// ---------------------------------------------------------------------------
// A pixel is taken on every clock edge with start high and busy low, one
// transaction per cycle sustained. Its color comes out with done high for a
// single cycle, in order. The front end classifies the hue and registers
// it, a two-entry fifo sits between front and back, and the back end is a
// three stage multiply pipeline that drains the fifo every cycle; since the
// output has no backpressure, busy stays low in normal operation. No clearing
// pass follows reset.
module hsv_to_rgb_pixel_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  hsv_pkg::pixel_t pixel,
  output logic            busy,
  output logic            done,
  output hsv_pkg::color_t color
);

  logic           front_valid;
  logic           front_ready;
  hsv_pkg::work_t front_work;
  logic           back_valid;
  hsv_pkg::work_t back_work;

  hsv_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .pixel      (pixel),
    .busy       (busy),
    .work_valid (front_valid),
    .work       (front_work),
    .work_ready (front_ready)
  );

  hsv_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_data  (front_work),
    .push_ready (front_ready),
    .pop_valid  (back_valid),
    .pop_data   (back_work)
  );

  hsv_back u_back (
    .clk        (clk),
    .rst        (rst),
    .work_valid (back_valid),
    .work       (back_work),
    .done       (done),
    .color      (color)
  );

endmodule

// ===== verif/rgb_result_check.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// rgb_result_check
// Watches the pixel and color channels of the hsv to rgb unit. Every
// accepted pixel is converted here to its expected color, and every color
// strobed out is compared field by field with the oldest one still owed.
// ---------------------------------------------------------------------------
module rgb_result_check (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            busy,
  input  hsv_pkg::pixel_t pixel,
  input  logic            done,
  input  hsv_pkg::color_t color,
  output int              errors,
  output int              pending
);

  localparam longint unsigned SPAN_60   = 3840;
  localparam longint unsigned SPAN_120  = 7680;
  localparam longint unsigned SCALE     = 255;
  localparam int              MAX_LINES = 40;

  hsv_pkg::color_t owed_colors[$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  // exact rational conversion, rounded half-up
  function automatic hsv_pkg::color_t hsv_to_rgb_color(hsv_pkg::pixel_t p);
    longint unsigned hue, sat, val, phase, gap, k, base;
    logic [7:0] full, lo, mid;
    hsv_pkg::color_t c;
    hue   = p.hue;
    sat   = p.saturation;
    val   = p.brightness;
    phase = hue % SPAN_120;
    gap   = (phase >= SPAN_60) ? phase - SPAN_60 : SPAN_60 - phase;
    k     = SPAN_60 - gap;
    base  = val * (SCALE - sat);
    full  = val[7:0];
    lo    = 8'((2 * base + SCALE) / (2 * SCALE));
    mid   = 8'((2 * (base * SPAN_60 + sat * val * k) + SCALE * SPAN_60)
               / (2 * SCALE * SPAN_60));
    if (p.hue <= hsv_pkg::HUE_BOUND1) begin
      c = '{full, mid, lo};
    end else if (p.hue <= hsv_pkg::HUE_BOUND2) begin
      c = '{mid, full, lo};
    end else if (p.hue <= hsv_pkg::HUE_BOUND3) begin
      c = '{lo, full, mid};
    end else if (p.hue <= hsv_pkg::HUE_BOUND4) begin
      c = '{lo, mid, full};
    end else if (p.hue <= hsv_pkg::HUE_BOUND5) begin
      c = '{mid, lo, full};
    end else begin
      c = '{full, lo, mid};
    end
    return c;
  endfunction

  task automatic report_mismatch(string msg);
    if (errors < MAX_LINES) begin
      $display("%0t mismatch: %s", $realtime, msg);
    end
    errors++;
  endtask

  always @(posedge clk) begin
    hsv_pkg::color_t want;
    if (!rst) begin
      // retire first so a pixel taken this cycle is never matched this cycle
      if (done) begin
        if (owed_colors.size() == 0) begin
          report_mismatch($sformatf("color %h with no pixel outstanding", color));
        end else begin
          want = owed_colors.pop_front();
          if (color.red !== want.red) begin
            report_mismatch($sformatf("red %h, want %h", color.red, want.red));
          end
          if (color.green !== want.green) begin
            report_mismatch($sformatf("green %h, want %h", color.green, want.green));
          end
          if (color.blue !== want.blue) begin
            report_mismatch($sformatf("blue %h, want %h", color.blue, want.blue));
          end
        end
      end
      if (start && !busy) begin
        owed_colors.push_back(hsv_to_rgb_color(pixel));
      end
      pending <= owed_colors.size();
    end
  end

endmodule

// ===== verif/tb_hsv_to_rgb_pixel_unit.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_hsv_to_rgb_pixel_unit
// Drives directed and random hsv pixels into the unit with random gaps,
// lets rgb_result_check predict and compare the colors, and gives the verdict.
// ---------------------------------------------------------------------------
module tb_hsv_to_rgb_pixel_unit;

  localparam int RANDOM_PIXELS = 580;
  localparam int QUIET_LIMIT   = 2000;
  localparam int DRAIN_CYCLES  = 8;

  logic            clk   = 1'b0;
  logic            rst   = 1'b1;
  logic            start = 1'b0;
  hsv_pkg::pixel_t pixel = '0;
  logic            busy;
  logic            done;
  hsv_pkg::color_t color;
  int              errors;
  int              pending;
  int              quiet_cycles = 0;

  always #5 clk = ~clk;

  hsv_to_rgb_pixel_unit u_top (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .pixel (pixel),
    .busy  (busy),
    .done  (done),
    .color (color)
  );

  rgb_result_check u_check (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .pixel   (pixel),
    .done    (done),
    .color   (color),
    .errors  (errors),
    .pending (pending)
  );

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (!rst) begin
      if ((start && !busy) || done) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_pixel(logic [14:0] hue, logic [7:0] sat, logic [7:0] val,
                            bit allow_idle);
    while (allow_idle && $urandom_range(99) < 36) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    pixel <= '{hue, sat, val};
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic [14:0] pick_hue();
    int bounds[7] = '{0, 3840, 7680, 11520, 15360, 19200, 23040};
    int h;
    int mode;
    mode = $urandom_range(99);
    if (mode < 65) begin
      h = $urandom_range(23040);
    end else if (mode < 80) begin
      // right around a sector edge
      h = bounds[$urandom_range(6)] + $urandom_range(4) - 2;
      if (h < 0) h = 0;
    end else if (mode < 90) begin
      h = $urandom_range(32767, 23041);
    end else begin
      h = $urandom_range(32767);
    end
    return 15'(h);
  endfunction

  function automatic logic [7:0] pick_level();
    int mode;
    mode = $urandom_range(99);
    if (mode < 8) return 8'd0;
    if (mode < 16) return 8'd255;
    return 8'($urandom_range(255));
  endfunction

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // sector edges, hue past 360 degrees, grays and black
    send_pixel(15'd0,     8'd255, 8'd255, 1'b1);
    send_pixel(15'd3840,  8'd255, 8'd255, 1'b1);
    send_pixel(15'd3841,  8'd255, 8'd255, 1'b1);
    send_pixel(15'd7680,  8'd200, 8'd255, 1'b1);
    send_pixel(15'd11520, 8'd255, 8'd128, 1'b1);
    send_pixel(15'd15360, 8'd128, 8'd200, 1'b1);
    send_pixel(15'd19200, 8'd255, 8'd255, 1'b1);
    send_pixel(15'd19201, 8'd255, 8'd255, 1'b1);
    send_pixel(15'd23040, 8'd255, 8'd255, 1'b1);
    send_pixel(15'd23041, 8'd100, 8'd200, 1'b1);
    send_pixel(15'd32767, 8'd255, 8'd255, 1'b1);
    send_pixel(15'd1920,  8'd255, 8'd255, 1'b1);
    send_pixel(15'd5760,  8'd128, 8'd77,  1'b1);
    send_pixel(15'd0,     8'd0,   8'd200, 1'b1);
    send_pixel(15'd12345, 8'd0,   8'd255, 1'b1);
    send_pixel(15'd9000,  8'd255, 8'd0,   1'b1);
    send_pixel(15'd17000, 8'd37,  8'd0,   1'b1);
    send_pixel(15'd2,     8'd1,   8'd1,   1'b1);
    send_pixel(15'd21000, 8'd254, 8'd254, 1'b1);
    send_pixel(15'd13440, 8'd255, 8'd255, 1'b1);
    send_pixel(15'd30000, 8'd0,   8'd0,   1'b1);

    for (int n = 0; n < RANDOM_PIXELS; n++) begin
      // back-to-back stretch in the middle
      send_pixel(pick_hue(), pick_level(), pick_level(), !(n >= 250 && n < 400));
    end
    @(negedge clk);
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/hsv_pkg.sv
design/hsv_front.sv
design/hsv_queue.sv
design/hsv_back.sv
design/hsv_to_rgb_pixel_unit.sv
verif/rgb_result_check.sv
verif/tb_hsv_to_rgb_pixel_unit.sv
